[hw/rtl/ordered_list_engine_unit_assert.svh]
// ----------------------------------------------------------------------------
// ordered list engine assertion macros
// shared concurrent assertion forms, clocked and held off during reset
// ----------------------------------------------------------------------------
`ifndef ORDERED_LIST_ENGINE_UNIT_ASSERT_SVH
`define ORDERED_LIST_ENGINE_UNIT_ASSERT_SVH

// condition holds at every edge out of reset
`define OLE_ASSERT_ALWAYS(label, clk, rst_n, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// consequence holds in the same cycle as the antecedent
`define OLE_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// consequence holds in the cycle after the antecedent
`define OLE_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[hw/rtl/olist_pkg.sv]
// ----------------------------------------------------------------------------
// olist_pkg
// field widths, command and status codes and controller states of the
// ordered list engine
// ----------------------------------------------------------------------------
package olist_pkg;

	// field widths of the command and response items
	localparam int ACT_W = 3;
	localparam int POS_W = 7;
	localparam int VAL_W = 32;
	localparam int ST_W  = 2;
	localparam int FND_W = 7;
	localparam int LEN_W = 7;

	// search miss or not a search: all ones
	localparam logic [FND_W-1:0] NOT_FOUND = '1;

	typedef enum logic [ACT_W-1:0] {
		ACT_APPEND = 3'd0,
		ACT_PUSH   = 3'd1,
		ACT_INSERT = 3'd2,
		ACT_DELETE = 3'd3,
		ACT_SEARCH = 3'd4,
		ACT_CLEAR  = 3'd5
	} action_t;

	typedef enum logic [ST_W-1:0] {
		ST_OK    = 2'd0,
		ST_FULL  = 2'd1,
		ST_RANGE = 2'd2
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_MOVE,
		S_FILL,
		S_SEARCH,
		S_RESULT
	} state_t;

endpackage

[hw/rtl/olist_if.sv]
// ----------------------------------------------------------------------------
// olist_if
// command and response channels of the ordered list engine, valid/ready
// ----------------------------------------------------------------------------

// command channel: one item per list operation
interface olist_cmd_if;
	logic                              valid;
	logic                              ready;
	logic [olist_pkg::ACT_W-1:0]       action;
	logic [olist_pkg::POS_W-1:0]       position_in;
	logic signed [olist_pkg::VAL_W-1:0] item_value;

	modport source (output valid, action, position_in, item_value, input ready);
	modport sink   (input valid, action, position_in, item_value, output ready);
endinterface

// response channel: one item per command
interface olist_rsp_if;
	logic                               valid;
	logic                               ready;
	logic [olist_pkg::ST_W-1:0]         status;
	logic signed [olist_pkg::FND_W-1:0] found_position;
	logic [olist_pkg::LEN_W-1:0]        list_length;

	modport source (output valid, status, found_position, list_length, input ready);
	modport sink   (input valid, status, found_position, list_length, output ready);
endinterface

[hw/rtl/olist_mem.sv]
// ----------------------------------------------------------------------------
// olist_mem
// entry store: one write port, one read port, read data registered
// ----------------------------------------------------------------------------
module olist_mem #(
	parameter int DEPTH  = 64,
	parameter int ADDR_W = 6,
	parameter int DATA_W = 32
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [DATA_W-1:0] wdata,
	input  logic              re,
	input  logic [ADDR_W-1:0] raddr,
	output logic [DATA_W-1:0] rdata
);

	logic [DATA_W-1:0] mem_q [DEPTH];
	logic [DATA_W-1:0] rdata_q;

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// read port, registered
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

[hw/rtl/ordered_list_engine_unit.sv]
// ----------------------------------------------------------------------------
// ordered_list_engine_unit
// bounded ordered list of signed 32-bit values held in a memory with one
// read and one write port; append, push, insert, delete, search and clear
// commands, one response each
//
//   channel  role    handshake      payload
//   cmd      sink    valid/ready    action, position_in, item_value
//   rsp      source  valid/ready    status, found_position, list_length
//
// commands that move nothing (append, clear, rejected items, delete of the
// last entry) answer from the idle state; insert and delete walk the entries
// that move, and search walks from index 0 up to a hit or the end of the list
// one entry moved or compared per cycle through the one read and one write port
// reset clears the length, the state and the response valid; entry contents are not cleared
// a stalled response holds its item; the next command is still taken and waits
// ----------------------------------------------------------------------------
`include "ordered_list_engine_unit_assert.svh"

module ordered_list_engine_unit #(
	parameter int CAPACITY = 64
) (
	input logic          clk,
	input logic          arst_n,
	olist_cmd_if.sink    cmd,
	olist_rsp_if.source  rsp
);

	localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CNT_W = $clog2(CAPACITY + 1);
	localparam int POS_W = olist_pkg::POS_W;
	localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;
	localparam int VAL_W = olist_pkg::VAL_W;
	localparam int FND_W = olist_pkg::FND_W;
	localparam int LEN_W = olist_pkg::LEN_W;

	olist_pkg::state_t  state_q, state_d;
	logic [CNT_W-1:0]   count_q, count_d;
	logic [IDX_W-1:0]   rd_ptr_q, rd_ptr_d;
	logic [CNT_W-1:0]   left_q, left_d;
	logic               up_q, up_d;
	logic [IDX_W-1:0]   pos_q, pos_d;
	logic [VAL_W-1:0]   val_q, val_d;
	olist_pkg::status_t res_status_q, res_status_d;
	logic [FND_W-1:0]   res_found_q, res_found_d;

	// read stage: address of the entry whose data arrives this cycle
	logic               vld_s1;
	logic [IDX_W-1:0]   addr_s1;

	// response register
	logic               out_vld_q;
	olist_pkg::status_t out_status_q, out_status_d;
	logic [FND_W-1:0]   out_found_q, out_found_d;
	logic [LEN_W-1:0]   out_len_q, out_len_d;
	logic               ld_out;

	// memory ports
	logic               mem_we, mem_re;
	logic [IDX_W-1:0]   mem_waddr, mem_raddr;
	logic [VAL_W-1:0]   mem_wdata, mem_rdata;

	// command decode
	logic               accept, load_ok, full;
	logic [CMP_W-1:0]   pos_ext, cnt_ext;
	logic [CNT_W-1:0]   ins_where, ins_moves, del_moves, pos_cnt;
	logic               del_range;
	logic               imm_done;
	olist_pkg::status_t imm_status;
	logic [FND_W-1:0]   imm_found;

	assign cmd.ready = (state_q == olist_pkg::S_IDLE);
	assign accept    = cmd.valid && cmd.ready;
	assign load_ok   = !out_vld_q || rsp.ready;

	// index arithmetic for insert and delete
	assign pos_ext   = CMP_W'(cmd.position_in);
	assign cnt_ext   = CMP_W'(count_q);
	assign pos_cnt   = CNT_W'(pos_ext);
	assign full      = (count_q == CNT_W'(CAPACITY));
	assign del_range = (pos_ext >= cnt_ext);
	assign ins_moves = count_q - ins_where;
	assign del_moves = count_q - CNT_W'(1) - pos_cnt;

	always_comb begin
		unique case (cmd.action)
			olist_pkg::ACT_PUSH:   ins_where = '0;
			olist_pkg::ACT_INSERT: ins_where = (pos_ext > cnt_ext) ? count_q : pos_cnt;
			default:               ins_where = count_q;
		endcase
	end

	// next state, memory control and response load
	always_comb begin
		state_d      = state_q;
		count_d      = count_q;
		rd_ptr_d     = rd_ptr_q;
		left_d       = left_q;
		up_d         = up_q;
		pos_d        = pos_q;
		val_d        = val_q;
		res_status_d = res_status_q;
		res_found_d  = res_found_q;
		mem_we       = 1'b0;
		mem_waddr    = '0;
		mem_wdata    = '0;
		mem_re       = 1'b0;
		mem_raddr    = rd_ptr_q;
		ld_out       = 1'b0;
		out_status_d = res_status_q;
		out_found_d  = res_found_q;
		out_len_d    = LEN_W'(count_q);
		imm_done     = 1'b0;
		imm_status   = olist_pkg::ST_OK;
		imm_found    = olist_pkg::NOT_FOUND;

		unique case (state_q)
			olist_pkg::S_IDLE: begin
				if (accept) begin
					val_d = cmd.item_value;
					unique case (cmd.action)
						olist_pkg::ACT_APPEND, olist_pkg::ACT_PUSH,
						olist_pkg::ACT_INSERT: begin
							if (full) begin
								imm_done   = 1'b1;
								imm_status = olist_pkg::ST_FULL;
							end else begin
								count_d = count_q + CNT_W'(1);
								if (ins_moves == '0) begin
									mem_we    = 1'b1;
									mem_waddr = IDX_W'(ins_where);
									mem_wdata = cmd.item_value;
									imm_done  = 1'b1;
								end else begin
									state_d  = olist_pkg::S_MOVE;
									up_d     = 1'b1;
									rd_ptr_d = IDX_W'(count_q - CNT_W'(1));
									left_d   = ins_moves;
									pos_d    = IDX_W'(ins_where);
								end
							end
						end
						olist_pkg::ACT_DELETE: begin
							if (del_range) begin
								imm_done   = 1'b1;
								imm_status = olist_pkg::ST_RANGE;
							end else begin
								count_d = count_q - CNT_W'(1);
								if (del_moves == '0) begin
									imm_done = 1'b1;
								end else begin
									state_d  = olist_pkg::S_MOVE;
									up_d     = 1'b0;
									rd_ptr_d = IDX_W'(pos_cnt + CNT_W'(1));
									left_d   = del_moves;
								end
							end
						end
						olist_pkg::ACT_SEARCH: begin
							if (count_q == '0) begin
								imm_done = 1'b1;
							end else begin
								state_d  = olist_pkg::S_SEARCH;
								rd_ptr_d = '0;
								left_d   = count_q;
							end
						end
						olist_pkg::ACT_CLEAR: begin
							count_d  = '0;
							imm_done = 1'b1;
						end
						default: begin
							imm_done = 1'b1;
						end
					endcase

					// commands that finish in the idle state answer now or park the result
					if (imm_done) begin
						if (load_ok) begin
							ld_out       = 1'b1;
							out_status_d = imm_status;
							out_found_d  = imm_found;
							out_len_d    = LEN_W'(count_d);
						end else begin
							state_d      = olist_pkg::S_RESULT;
							res_status_d = imm_status;
							res_found_d  = imm_found;
						end
					end
				end
			end

			olist_pkg::S_MOVE: begin
				// write back the entry read last cycle one place up or down
				if (vld_s1) begin
					mem_we    = 1'b1;
					mem_waddr = up_q ? (addr_s1 + IDX_W'(1)) : (addr_s1 - IDX_W'(1));
					mem_wdata = mem_rdata;
				end
				if (left_q != '0) begin
					mem_re   = 1'b1;
					rd_ptr_d = up_q ? (rd_ptr_q - IDX_W'(1)) : (rd_ptr_q + IDX_W'(1));
					left_d   = left_q - CNT_W'(1);
				end else begin
					state_d      = up_q ? olist_pkg::S_FILL : olist_pkg::S_RESULT;
					res_status_d = olist_pkg::ST_OK;
					res_found_d  = olist_pkg::NOT_FOUND;
				end
			end

			olist_pkg::S_FILL: begin
				mem_we    = 1'b1;
				mem_waddr = pos_q;
				mem_wdata = val_q;
				state_d   = olist_pkg::S_RESULT;
			end

			olist_pkg::S_SEARCH: begin
				res_status_d = olist_pkg::ST_OK;
				if (vld_s1 && (mem_rdata == val_q)) begin
					res_found_d = FND_W'(addr_s1);
					state_d     = olist_pkg::S_RESULT;
				end else if (left_q != '0) begin
					mem_re   = 1'b1;
					rd_ptr_d = rd_ptr_q + IDX_W'(1);
					left_d   = left_q - CNT_W'(1);
				end else if (!vld_s1) begin
					res_found_d = olist_pkg::NOT_FOUND;
					state_d     = olist_pkg::S_RESULT;
				end
			end

			olist_pkg::S_RESULT: begin
				if (load_ok) begin
					ld_out  = 1'b1;
					state_d = olist_pkg::S_IDLE;
				end
			end

			default: begin
				state_d = olist_pkg::S_IDLE;
			end
		endcase
	end

	// controller registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= olist_pkg::S_IDLE;
			count_q <= '0;
			vld_s1  <= 1'b0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
			vld_s1  <= mem_re;
		end
	end

	// working payload, no reset
	always_ff @(posedge clk) begin
		rd_ptr_q     <= rd_ptr_d;
		left_q       <= left_d;
		up_q         <= up_d;
		pos_q        <= pos_d;
		val_q        <= val_d;
		res_status_q <= res_status_d;
		res_found_q  <= res_found_d;
		addr_s1      <= mem_raddr;
	end

	// response register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (ld_out) begin
			out_vld_q <= 1'b1;
		end else if (rsp.ready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ld_out) begin
			out_status_q <= out_status_d;
			out_found_q  <= out_found_d;
			out_len_q    <= out_len_d;
		end
	end

	assign rsp.valid          = out_vld_q;
	assign rsp.status         = out_status_q;
	assign rsp.found_position = out_found_q;
	assign rsp.list_length    = out_len_q;

	// entry store
	olist_mem #(
		.DEPTH  (CAPACITY),
		.ADDR_W (IDX_W),
		.DATA_W (VAL_W)
	) u_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	// checks
	`OLE_ASSERT_ALWAYS(a_count_bound, clk, arst_n, count_q <= CNT_W'(CAPACITY), "length beyond capacity")
	`OLE_ASSERT_IMPLY(a_no_rw_clash, clk, arst_n, mem_we && mem_re, mem_waddr != mem_raddr, "read and write hit one entry")
	`OLE_ASSERT_IMPLY(a_s1_in_walk, clk, arst_n, vld_s1, state_q == olist_pkg::S_MOVE || state_q == olist_pkg::S_SEARCH, "read data outside a walk")
	`OLE_ASSERT_NEXT(a_count_steady, clk, arst_n, state_q != olist_pkg::S_IDLE, count_q == $past(count_q), "length changed during a walk")

endmodule
